@@ rtl/calendar_serial_day_converter_unit_defines.svh @@
// Assertion macros shared by the calendar serial day converter RTL.
`ifndef CALENDAR_SERIAL_DAY_CONVERTER_UNIT_DEFINES_SVH
`define CALENDAR_SERIAL_DAY_CONVERTER_UNIT_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define CSDC_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define CSDC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/csdc_pkg.sv @@
// Constants, types and calendar helper functions for the serial day converter.
package csdc_pkg;

   typedef enum logic {
      OP_TO_SERIAL = 1'b0,
      OP_TO_DATE   = 1'b1
   } op_type;

   localparam logic [13:0] YEAR_MIN       = 14'd1900;
   localparam logic [13:0] YEAR_MAX       = 14'd9999;
   localparam logic [13:0] CENTURY_RESET  = 14'd2000;
   localparam logic [6:0]  TWO_DIGIT_LIM  = 7'd100;
   localparam logic [3:0]  MONTH_FIRST    = 4'd1;
   localparam logic [3:0]  MONTH_FEB      = 4'd2;
   localparam logic [3:0]  MONTH_LAST     = 4'd12;
   localparam logic [4:0]  HOUR_MAX       = 5'd23;
   localparam logic [5:0]  MINSEC_MAX     = 6'd59;
   localparam logic [21:0] SERIAL_MAX     = 22'd2958525;
   localparam logic [16:0] SECS_PER_DAY   = 17'd86400;
   localparam logic [11:0] SECS_PER_HOUR  = 12'd3600;
   localparam logic [5:0]  SECS_PER_MIN   = 6'd60;
   localparam logic [10:0] DAYS_PER_BLOCK = 11'd1461;
   localparam logic [8:0]  DAYS_LEAP_YEAR = 9'd366;
   localparam logic [8:0]  DAYS_YEAR      = 9'd365;
   localparam logic [4:0]  FEB_LEAP_LEN   = 5'd29;
   localparam logic [2:0]  WEEKDAY_OFFSET = 3'd6;
   localparam logic [2:0]  DAYS_PER_WEEK  = 3'd7;

   // Reciprocals: floor(x * RECIP / 2^SHIFT) equals x / divisor over the used range.
   localparam logic [21:0] BLOCK_RECIP = 22'd2939745;   // 1461, shift 32
   localparam logic [15:0] HOUR_RECIP  = 16'd37283;     // 3600, shift 27
   localparam logic [12:0] MIN_RECIP   = 13'd4370;      // 60, shift 18
   localparam logic [24:0] WEEK_RECIP  = 25'd19173962;  // 7, shift 27

   localparam logic [4:0] MONTH_LEN [12] = '{
      5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
   };

   localparam logic [8:0] CUM_DAYS [12] = '{
      9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
      9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
   };

   // Length of a month, zero for a code that is not a month.
   function automatic logic [4:0] days_in_month(input logic [3:0] month, input logic leap);
      logic [4:0] len;
      len = 5'd0;
      if (month >= MONTH_FIRST && month <= MONTH_LAST) begin
         len = MONTH_LEN[month - MONTH_FIRST];
         if (month == MONTH_FEB && leap) begin
            len = FEB_LEAP_LEN;
         end
      end
      return len;
   endfunction

   // Days in the year before the first of the month.
   function automatic logic [8:0] days_before(input logic [3:0] month, input logic leap);
      logic [8:0] cum;
      cum = 9'd0;
      if (month >= MONTH_FIRST && month <= MONTH_LAST) begin
         cum = CUM_DAYS[month - MONTH_FIRST];
         if (month > MONTH_FEB && leap) begin
            cum = cum + 9'd1;
         end
      end
      return cum;
   endfunction

endpackage

@@ rtl/calendar_serial_day_converter_unit.sv @@
// Calendar date-time to serial day converter and back, as a four-stage pipeline.
//
// Request words carry an operation code and both sets of fields. Code OP_TO_SERIAL
// checks a calendar date-time (two-digit years get the century register added) and
// returns the serial day (1 is 1 Jan 1900) and seconds past midnight. Code OP_TO_DATE
// splits a serial day and second of day into the calendar fields and the weekday.
// A word is taken at a clock edge where req_valid is high and req_stall is low, and
// one result word leaves on the rsp channel under the same rule.
// The result word is registered in stage one, stage two, stage three and the output
// stage. Throughput: one word per cycle while no result word is held by rsp_stall.
// When a result word is held by rsp_stall the whole pipeline freezes and req_stall
// rises in the same cycle, so no word is lost or repeated. The user must write the
// century register (csr_wr_en, csr_wr_data) only while the unit is idle; the unit
// itself does not enforce this. A synchronous reset empties the pipeline and sets
// the century to 2000. Out of range fields give valid_res low and the default
// 1900-01-01 00:00:00.
`include "calendar_serial_day_converter_unit_defines.svh"

module calendar_serial_day_converter_unit
   import csdc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [13:0] csr_wr_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_op,
   input  logic [13:0] req_year_in,
   input  logic [3:0]  req_month_in,
   input  logic [4:0]  req_day_in,
   input  logic [4:0]  req_hour_in,
   input  logic [5:0]  req_minute_in,
   input  logic [5:0]  req_second_in,
   input  logic [21:0] req_serial_in,
   input  logic [16:0] req_seconds_of_day_in,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [21:0] rsp_serial_out,
   output logic [16:0] rsp_seconds_of_day_out,
   output logic [13:0] rsp_year_out,
   output logic [3:0]  rsp_month_out,
   output logic [4:0]  rsp_day_out,
   output logic [4:0]  rsp_hour_out,
   output logic [5:0]  rsp_minute_out,
   output logic [5:0]  rsp_second_out,
   output logic [2:0]  rsp_weekday_out,
   output logic        rsp_valid_res
);

   logic        adv;
   logic [13:0] century_ff;
   logic        v1_ff, v2_ff, v3_ff, rsp_valid_ff;

   // Stage 1: checks and the first products.
   op_type      op_in, op1_ff;
   logic [14:0] yr_sum;
   logic        ok_date, ok_serial;
   logic        ok1_in, ok1_ff;
   logic [12:0] yoff1_in, yoff1_ff;
   logic [3:0]  mon1_ff;
   logic [4:0]  day1_ff, hour1_ff;
   logic [5:0]  min1_ff, sec1_ff;
   logic [21:0] sdm1_in, sdm1_ff;
   logic [43:0] pblk1_in, pblk1_ff;
   logic [32:0] phr1_in, phr1_ff;
   logic [16:0] secs1_ff;
   logic [22:0] wsum1_in, wsum1_ff;
   logic [47:0] pwk1_in, pwk1_ff;

   // Stage 2.
   op_type      op2_ff;
   logic        ok2_ff;
   logic        leap2;
   logic [21:0] yacc2_in, yacc2_ff;
   logic [10:0] ypart2_in, ypart2_ff;
   logic [8:0]  mday2_in, mday2_ff;
   logic [16:0] sodh2_in, sodh2_ff;
   logic [11:0] sodms2_in, sodms2_ff;
   logic [11:0] blk2_in, blk2_ff;
   logic [22:0] blk_days;
   logic [21:0] r_full;
   logic [10:0] r2_ff;
   logic [4:0]  hr2_in, hr2_ff;
   logic [16:0] hr_secs, rem_full;
   logic [11:0] rem2_ff;
   logic [20:0] wq2_in, wq2_ff;
   logic [22:0] wsum2_ff;

   // Stage 3.
   op_type      op3_ff;
   logic        ok3_ff;
   logic [21:0] serial3_in, serial3_ff;
   logic [16:0] sod3_in, sod3_ff;
   logic [10:0] r0;
   logic [1:0]  yoff3;
   logic [8:0]  doy3_in, doy3_ff;
   logic [13:0] year3_in, year3_ff;
   logic        leap3_ff;
   logic [24:0] pmin3_in, pmin3_ff;
   logic [11:0] rem3_ff;
   logic [4:0]  hr3_ff;
   logic [23:0] wq7;
   logic [22:0] wdiff;
   logic [2:0]  wd3_ff;

   // Output stage.
   logic [3:0]  mo_calc;
   logic [8:0]  dday;
   logic [5:0]  mi_calc;
   logic [11:0] mi60, sdiff;
   logic [21:0] serial_o_in, serial_o_ff;
   logic [16:0] sod_o_in, sod_o_ff;
   logic [13:0] year_o_in, year_o_ff;
   logic [3:0]  mon_o_in, mon_o_ff;
   logic [4:0]  day_o_in, day_o_ff, hr_o_in, hr_o_ff;
   logic [5:0]  min_o_in, min_o_ff, sec_o_in, sec_o_ff;
   logic [2:0]  wd_o_in, wd_o_ff;
   logic        res_o_ff;

   // The pipeline moves as one unless the output word is being held.
   assign adv       = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !adv;

   // ---------------- Stage 1 ----------------
   assign op_in  = op_type'(req_op);
   assign yr_sum = (req_year_in < 14'(TWO_DIGIT_LIM)) ?
                   ({1'b0, req_year_in} + {1'b0, century_ff}) : {1'b0, req_year_in};

   assign ok_date = (yr_sum >= {1'b0, YEAR_MIN}) && (yr_sum <= {1'b0, YEAR_MAX}) &&
                    (req_month_in >= MONTH_FIRST) && (req_month_in <= MONTH_LAST) &&
                    (req_day_in >= 5'd1) &&
                    (req_day_in <= days_in_month(req_month_in, yr_sum[1:0] == 2'd0)) &&
                    (req_hour_in <= HOUR_MAX) && (req_minute_in <= MINSEC_MAX) &&
                    (req_second_in <= MINSEC_MAX);

   assign ok_serial = (req_serial_in >= 22'd1) && (req_serial_in <= SERIAL_MAX) &&
                      (req_seconds_of_day_in < SECS_PER_DAY);

   assign ok1_in   = (op_in == OP_TO_SERIAL) ? ok_date : ok_serial;
   assign yoff1_in = 13'(yr_sum - {1'b0, YEAR_MIN});
   assign sdm1_in  = req_serial_in - 22'd1;
   assign pblk1_in = sdm1_in * BLOCK_RECIP;
   assign phr1_in  = req_seconds_of_day_in * HOUR_RECIP;
   assign wsum1_in = {1'b0, req_serial_in} + 23'(WEEKDAY_OFFSET);
   assign pwk1_in  = wsum1_in * WEEK_RECIP;

   // ---------------- Stage 2 ----------------
   // 1900 is a multiple of four, so the year offset shows the leap years too.
   assign leap2     = (yoff1_ff[1:0] == 2'd0);
   assign yacc2_in  = 22'(yoff1_ff[12:2] * DAYS_PER_BLOCK);
   assign ypart2_in = leap2 ? 11'd0 : 11'(yoff1_ff[1:0] * DAYS_YEAR + 11'd1);
   assign mday2_in  = days_before(mon1_ff, leap2) + 9'(day1_ff);
   assign sodh2_in  = 17'(hour1_ff * SECS_PER_HOUR);
   assign sodms2_in = 12'(min1_ff * SECS_PER_MIN) + 12'(sec1_ff);

   assign blk2_in  = pblk1_ff[43:32];
   assign blk_days = blk2_in * DAYS_PER_BLOCK;
   assign r_full   = sdm1_ff - blk_days[21:0];
   assign hr2_in   = phr1_ff[31:27];
   assign hr_secs  = 17'(hr2_in * SECS_PER_HOUR);
   assign rem_full = secs1_ff - hr_secs;
   assign wq2_in   = pwk1_ff[47:27];

   // ---------------- Stage 3 ----------------
   assign serial3_in = yacc2_ff + 22'(ypart2_ff) + 22'(mday2_ff);
   assign sod3_in    = sodh2_ff + 17'(sodms2_ff);

   // Day within the four-year block, from one; the first year of a block is the leap one.
   assign r0 = r2_ff + 11'd1;

   always_comb begin
      if (r0 <= 11'(DAYS_LEAP_YEAR)) begin
         yoff3   = 2'd0;
         doy3_in = r0[8:0];
      end else if (r0 <= 11'(DAYS_LEAP_YEAR) + 11'(DAYS_YEAR)) begin
         yoff3   = 2'd1;
         doy3_in = 9'(r0 - 11'(DAYS_LEAP_YEAR));
      end else if (r0 <= 11'(DAYS_LEAP_YEAR) + 11'(DAYS_YEAR) + 11'(DAYS_YEAR)) begin
         yoff3   = 2'd2;
         doy3_in = 9'(r0 - 11'(DAYS_LEAP_YEAR) - 11'(DAYS_YEAR));
      end else begin
         yoff3   = 2'd3;
         doy3_in = 9'(r0 - 11'(DAYS_LEAP_YEAR) - 11'(DAYS_YEAR) - 11'(DAYS_YEAR));
      end
   end

   assign year3_in = YEAR_MIN + {blk2_ff, 2'b00} + 14'(yoff3);
   assign pmin3_in = rem2_ff * MIN_RECIP;
   assign wq7      = wq2_ff * DAYS_PER_WEEK;
   assign wdiff    = wsum2_ff - wq7[22:0];

   // ---------------- Output stage ----------------
   always_comb begin
      mo_calc = MONTH_FIRST;
      for (int j = 2; j <= 12; j++) begin
         if (doy3_ff > days_before(4'(j), leap3_ff)) begin
            mo_calc = 4'(j);
         end
      end
   end

   assign dday    = doy3_ff - days_before(mo_calc, leap3_ff);
   assign mi_calc = pmin3_ff[23:18];
   assign mi60    = 12'(mi_calc * SECS_PER_MIN);
   assign sdiff   = rem3_ff - mi60;

   always_comb begin
      serial_o_in = 22'd0;
      sod_o_in    = 17'd0;
      year_o_in   = YEAR_MIN;
      mon_o_in    = MONTH_FIRST;
      day_o_in    = 5'd1;
      hr_o_in     = 5'd0;
      min_o_in    = 6'd0;
      sec_o_in    = 6'd0;
      wd_o_in     = 3'd0;
      case (op3_ff)
         OP_TO_SERIAL: begin
            if (ok3_ff) begin
               serial_o_in = serial3_ff;
               sod_o_in    = sod3_ff;
            end
         end
         OP_TO_DATE: begin
            if (ok3_ff) begin
               year_o_in = year3_ff;
               mon_o_in  = mo_calc;
               day_o_in  = dday[4:0];
               hr_o_in   = hr3_ff;
               min_o_in  = mi_calc;
               sec_o_in  = sdiff[5:0];
               wd_o_in   = wd3_ff;
            end
         end
         default: begin
            serial_o_in = 22'd0;
         end
      endcase
   end

   // ---------------- Registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         century_ff   <= CENTURY_RESET;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            century_ff <= csr_wr_data;
         end
         if (adv) begin
            v1_ff        <= req_valid;
            v2_ff        <= v1_ff;
            v3_ff        <= v2_ff;
            rsp_valid_ff <= v3_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         op1_ff    <= op_in;
         ok1_ff    <= ok1_in;
         yoff1_ff  <= yoff1_in;
         mon1_ff   <= req_month_in;
         day1_ff   <= req_day_in;
         hour1_ff  <= req_hour_in;
         min1_ff   <= req_minute_in;
         sec1_ff   <= req_second_in;
         sdm1_ff   <= sdm1_in;
         pblk1_ff  <= pblk1_in;
         phr1_ff   <= phr1_in;
         secs1_ff  <= req_seconds_of_day_in;
         wsum1_ff  <= wsum1_in;
         pwk1_ff   <= pwk1_in;

         op2_ff    <= op1_ff;
         ok2_ff    <= ok1_ff;
         yacc2_ff  <= yacc2_in;
         ypart2_ff <= ypart2_in;
         mday2_ff  <= mday2_in;
         sodh2_ff  <= sodh2_in;
         sodms2_ff <= sodms2_in;
         blk2_ff   <= blk2_in;
         r2_ff     <= r_full[10:0];
         hr2_ff    <= hr2_in;
         rem2_ff   <= rem_full[11:0];
         wq2_ff    <= wq2_in;
         wsum2_ff  <= wsum1_ff;

         op3_ff     <= op2_ff;
         ok3_ff     <= ok2_ff;
         serial3_ff <= serial3_in;
         sod3_ff    <= sod3_in;
         doy3_ff    <= doy3_in;
         year3_ff   <= year3_in;
         leap3_ff   <= (yoff3 == 2'd0);
         pmin3_ff   <= pmin3_in;
         rem3_ff    <= rem2_ff;
         hr3_ff     <= hr2_ff;
         wd3_ff     <= wdiff[2:0];

         serial_o_ff <= serial_o_in;
         sod_o_ff    <= sod_o_in;
         year_o_ff   <= year_o_in;
         mon_o_ff    <= mon_o_in;
         day_o_ff    <= day_o_in;
         hr_o_ff     <= hr_o_in;
         min_o_ff    <= min_o_in;
         sec_o_ff    <= sec_o_in;
         wd_o_ff     <= wd_o_in;
         res_o_ff    <= ok3_ff;
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_serial_out         = serial_o_ff;
   assign rsp_seconds_of_day_out = sod_o_ff;
   assign rsp_year_out           = year_o_ff;
   assign rsp_month_out          = mon_o_ff;
   assign rsp_day_out            = day_o_ff;
   assign rsp_hour_out           = hr_o_ff;
   assign rsp_minute_out         = min_o_ff;
   assign rsp_second_out         = sec_o_ff;
   assign rsp_weekday_out        = wd_o_ff;
   assign rsp_valid_res          = res_o_ff;

   // ---------------- Assertions ----------------
   `CSDC_ASSERT_SAME(a_month_day_range, rsp_valid,
      rsp_month_out >= 4'd1 && rsp_month_out <= 4'd12 && rsp_day_out >= 5'd1,
      "result month or day out of range")
   `CSDC_ASSERT_SAME(a_invalid_zero, rsp_valid && !rsp_valid_res,
      rsp_serial_out == 22'd0 && rsp_seconds_of_day_out == 17'd0,
      "invalid result carries a non-zero serial")
   `CSDC_ASSERT_SAME(a_weekday_range, rsp_valid, rsp_weekday_out <= 3'd6,
      "weekday above Saturday")
   `CSDC_ASSERT_SAME(a_stage_fill, $rose(v2_ff), $past(v1_ff),
      "stage two filled from an empty stage one")
   `CSDC_ASSERT_NEXT(a_stage_drain, v3_ff && !req_stall, rsp_valid,
      "stage three word did not reach the output")

endmodule

@@ test/tb_calendar_serial_day_converter_unit.sv @@
// Self-checking testbench for the calendar serial day converter unit.
`timescale 1ns / 100ps

module tb_calendar_serial_day_converter_unit
   import csdc_pkg::*;
();

   localparam int CYCLE_LIMIT   = 200000;
   localparam int PHASE_WORDS   = 460;
   localparam int LATENCY_SLACK = 8;

   typedef struct packed {
      op_type      op;
      logic [13:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
      logic [21:0] serial;
      logic [16:0] sod;
   } conv_word_type;

   typedef struct packed {
      logic [21:0] serial;
      logic [16:0] sod;
      logic [13:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
      logic [2:0]  weekday;
      logic        ok;
   } conv_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wr_en = 1'b0;
   logic [13:0] csr_wr_data = 14'd0;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_op = 1'b0;
   logic [13:0] req_year_in = 14'd0;
   logic [3:0]  req_month_in = 4'd0;
   logic [4:0]  req_day_in = 5'd0;
   logic [4:0]  req_hour_in = 5'd0;
   logic [5:0]  req_minute_in = 6'd0;
   logic [5:0]  req_second_in = 6'd0;
   logic [21:0] req_serial_in = 22'd0;
   logic [16:0] req_seconds_of_day_in = 17'd0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [21:0] rsp_serial_out;
   logic [16:0] rsp_seconds_of_day_out;
   logic [13:0] rsp_year_out;
   logic [3:0]  rsp_month_out;
   logic [4:0]  rsp_day_out;
   logic [4:0]  rsp_hour_out;
   logic [5:0]  rsp_minute_out;
   logic [5:0]  rsp_second_out;
   logic [2:0]  rsp_weekday_out;
   logic        rsp_valid_res;

   conv_result_type conversion_queue[$];
   conv_word_type   directed_words[$];
   conv_result_type directed_results[$];
   bit              directed_known[$];
   logic [13:0]     century_reg = CENTURY_RESET;
   int              cycle_count = 0;
   int              mismatch_count = 0;
   int              serial_words = 0;
   int              date_words = 0;
   int              rejected_words = 0;
   int              century_writes = 0;

   calendar_serial_day_converter_unit uut (
      .clock                  (clock),
      .reset                  (reset),
      .csr_wr_en              (csr_wr_en),
      .csr_wr_data            (csr_wr_data),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_op                 (req_op),
      .req_year_in            (req_year_in),
      .req_month_in           (req_month_in),
      .req_day_in             (req_day_in),
      .req_hour_in            (req_hour_in),
      .req_minute_in          (req_minute_in),
      .req_second_in          (req_second_in),
      .req_serial_in          (req_serial_in),
      .req_seconds_of_day_in  (req_seconds_of_day_in),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_serial_out         (rsp_serial_out),
      .rsp_seconds_of_day_out (rsp_seconds_of_day_out),
      .rsp_year_out           (rsp_year_out),
      .rsp_month_out          (rsp_month_out),
      .rsp_day_out            (rsp_day_out),
      .rsp_hour_out           (rsp_hour_out),
      .rsp_minute_out         (rsp_minute_out),
      .rsp_second_out         (rsp_second_out),
      .rsp_weekday_out        (rsp_weekday_out),
      .rsp_valid_res          (rsp_valid_res)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("tb_calendar_serial_day_converter_unit failed");
      $finish;
   end

   // Every fourth year is a leap year here, the century years included.
   function automatic int unsigned month_days(input int unsigned m, input int unsigned y);
      if (m < 1 || m > 12) begin
         return 0;
      end
      if (m == 2) begin
         return (y % 4 == 0) ? 29 : 28;
      end
      if (m == 4 || m == 6 || m == 9 || m == 11) begin
         return 30;
      end
      return 31;
   endfunction

   function automatic conv_result_type date_result(input int unsigned y, m, d, h, n, s, wd);
      conv_result_type r;
      r = '0;
      r.year    = 14'(y);
      r.month   = 4'(m);
      r.day     = 5'(d);
      r.hour    = 5'(h);
      r.minute  = 6'(n);
      r.second  = 6'(s);
      r.weekday = 3'(wd);
      r.ok      = 1'b1;
      return r;
   endfunction

   function automatic conv_result_type rejected_result();
      conv_result_type r;
      r = date_result(1900, 1, 1, 0, 0, 0, 0);
      r.ok = 1'b0;
      return r;
   endfunction

   function automatic conv_result_type serial_result(input int unsigned sd,
                                                     input int unsigned secs);
      conv_result_type r;
      r = rejected_result();
      r.serial = 22'(sd);
      r.sod    = 17'(secs);
      r.ok     = 1'b1;
      return r;
   endfunction

   // Expected result word for one request under the given century.
   function automatic conv_result_type convert_word(input conv_word_type w,
                                                    input logic [13:0] century);
      conv_result_type r;
      int unsigned     y;
      int unsigned     days;
      int unsigned     m;
      r = rejected_result();
      if (w.op == OP_TO_SERIAL) begin
         y = w.year;
         if (y < 100) begin
            y = y + century;
         end
         if (y >= YEAR_MIN && y <= YEAR_MAX && w.month >= 1 && w.month <= 12 &&
             w.day >= 1 && w.day <= month_days(w.month, y) && w.hour <= 23 &&
             w.minute <= 59 && w.second <= 59) begin
            days = (y - 1900) / 4 * 1461;
            if (y % 4 != 0) begin
               days = days + (y % 4) * 365 + 1;
            end
            for (m = 1; m < w.month; m++) begin
               days = days + month_days(m, y);
            end
            r.serial = 22'(days + w.day);
            r.sod    = 17'(w.hour * 3600 + w.minute * 60 + w.second);
            r.ok     = 1'b1;
         end
      end else if (w.serial >= 1 && w.serial <= SERIAL_MAX && w.sod < SECS_PER_DAY) begin
         y = 1900 + (w.serial - 1) / 1461 * 4;
         days = (w.serial - 1) % 1461 + 1;
         // The first year of each four-year block is the leap year.
         if (days > 366) begin
            y = y + 1;
            days = days - 366;
            while (days > 365) begin
               y = y + 1;
               days = days - 365;
            end
         end
         m = 1;
         while (m < 12 && days > month_days(m, y)) begin
            days = days - month_days(m, y);
            m = m + 1;
         end
         r = date_result(y, m, days, w.sod / 3600, (w.sod % 3600) / 60, w.sod % 60,
                         (w.serial + 6) % 7);
      end
      return r;
   endfunction

   function automatic conv_word_type date_word(input int unsigned y, m, d, h, n, s);
      conv_word_type w;
      w.op     = OP_TO_SERIAL;
      w.year   = 14'(y);
      w.month  = 4'(m);
      w.day    = 5'(d);
      w.hour   = 5'(h);
      w.minute = 6'(n);
      w.second = 6'(s);
      w.serial = 22'($urandom);
      w.sod    = 17'($urandom);
      return w;
   endfunction

   function automatic conv_word_type serial_word(input int unsigned sd, input int unsigned secs);
      conv_word_type w;
      w = date_word($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      w.op     = OP_TO_DATE;
      w.serial = 22'(sd);
      w.sod    = 17'(secs);
      return w;
   endfunction

   // Mostly well-formed dates and serials, with some words out of range.
   function automatic conv_word_type random_word();
      conv_word_type w;
      int unsigned   pick;
      int unsigned   y;
      int unsigned   len;
      w = serial_word($urandom, $urandom);
      w.op = op_type'(1'($urandom_range(0, 1)));
      pick = $urandom_range(0, 99);
      if (w.op == OP_TO_SERIAL) begin
         if (pick < 20) begin
            w.year = 14'($urandom_range(0, 99));
         end else if (pick < 85) begin
            w.year = 14'($urandom_range(1900, 9999));
         end else if (pick < 89) begin
            w.year = 14'($urandom_range(1895, 1905));
         end else if (pick < 93) begin
            w.year = 14'($urandom_range(9995, 10005));
         end
         if ($urandom_range(0, 9) != 0) begin
            w.month = 4'($urandom_range(1, 12));
         end
         y = (w.year < 100) ? w.year + century_reg : w.year;
         len = month_days(w.month, y);
         if (len != 0 && $urandom_range(0, 9) != 0) begin
            w.day = 5'(($urandom_range(0, 3) == 0) ? len : $urandom_range(1, len));
         end
         if ($urandom_range(0, 14) != 0) begin
            w.hour = 5'($urandom_range(0, 23));
         end
         if ($urandom_range(0, 14) != 0) begin
            w.minute = 6'($urandom_range(0, 59));
         end
         if ($urandom_range(0, 14) != 0) begin
            w.second = 6'($urandom_range(0, 59));
         end
      end else begin
         if (pick < 12) begin
            w.serial = 22'($urandom_range(1, 1500));
         end else if (pick < 80) begin
            w.serial = 22'($urandom_range(1, SERIAL_MAX));
         end else if (pick < 90) begin
            w.serial = 22'($urandom_range(SERIAL_MAX - 1500, SERIAL_MAX + 3));
         end
         if ($urandom_range(0, 14) != 0) begin
            w.sod = 17'($urandom_range(0, SECS_PER_DAY - 1));
         end
      end
      return w;
   endfunction

   task automatic add_row(input conv_word_type w, input bit known, input conv_result_type r);
      directed_words.push_back(w);
      directed_known.push_back(known);
      directed_results.push_back(r);
   endtask

   // Holds the word on the ports until it is taken, then records what must come back.
   task automatic send_word(input conv_word_type w, input conv_result_type want);
      req_valid             <= 1'b1;
      req_op                <= w.op;
      req_year_in           <= w.year;
      req_month_in          <= w.month;
      req_day_in            <= w.day;
      req_hour_in           <= w.hour;
      req_minute_in         <= w.minute;
      req_second_in         <= w.second;
      req_serial_in         <= w.serial;
      req_seconds_of_day_in <= w.sod;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      conversion_queue.push_back(want);
      if (w.op == OP_TO_SERIAL) begin
         serial_words++;
      end else begin
         date_words++;
      end
      if (!want.ok) begin
         rejected_words++;
      end
   endtask

   task automatic send_stream(input int count);
      int burst;
      conv_word_type w;
      burst = $urandom_range(1, 40);
      for (int i = 0; i < count; i++) begin
         w = random_word();
         send_word(w, convert_word(w, century_reg));
         burst--;
         if (burst == 0 && i + 1 < count) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
            burst = $urandom_range(1, 40);
         end
      end
      req_valid <= 1'b0;
   endtask

   task automatic drain_results();
      while (conversion_queue.size() != 0) begin
         @(posedge clock);
      end
      repeat (LATENCY_SLACK) @(posedge clock);
   endtask

   task automatic write_century(input logic [13:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      century_reg = value;
      century_writes++;
      csr_wr_en <= 1'b0;
   endtask

   task automatic check_field(input string name, input logic [21:0] want, input logic [21:0] got);
      if (want !== got) begin
         mismatch_count++;
         $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      end
   endtask

   // The receiver switches at random between stall habits: never, sometimes, mostly, or a fixed pattern.
   always @(posedge clock) begin : stall_pattern
      static int stall_mode = 0;
      static int stall_tick = 0;
      stall_tick++;
      if (stall_tick % 61 == 0) begin
         stall_mode = $urandom_range(0, 3);
      end
      case (stall_mode)
         0: begin
            rsp_stall <= 1'b0;
         end
         1: begin
            rsp_stall <= ($urandom_range(0, 3) == 0);
         end
         2: begin
            rsp_stall <= ($urandom_range(0, 3) != 0);
         end
         default: begin
            rsp_stall <= (stall_tick % 5 < 2);
         end
      endcase
   end

   always @(posedge clock) begin : result_check
      conv_result_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (conversion_queue.size() == 0) begin
            mismatch_count++;
            $display("%0t: result word arrived with none expected", $time);
         end else begin
            want = conversion_queue.pop_front();
            check_field("serial_out", 22'(want.serial), 22'(rsp_serial_out));
            check_field("seconds_of_day_out", 22'(want.sod), 22'(rsp_seconds_of_day_out));
            check_field("year_out", 22'(want.year), 22'(rsp_year_out));
            check_field("month_out", 22'(want.month), 22'(rsp_month_out));
            check_field("day_out", 22'(want.day), 22'(rsp_day_out));
            check_field("hour_out", 22'(want.hour), 22'(rsp_hour_out));
            check_field("minute_out", 22'(want.minute), 22'(rsp_minute_out));
            check_field("second_out", 22'(want.second), 22'(rsp_second_out));
            check_field("weekday_out", 22'(want.weekday), 22'(rsp_weekday_out));
            check_field("valid_res", 22'(want.ok), 22'(rsp_valid_res));
         end
      end
   end

   initial begin
      logic [13:0] centuries[4];
      conv_result_type want;
      int n;
      centuries[0] = 14'd1900;
      centuries[1] = 14'd9900;
      centuries[2] = 14'($urandom_range(1901, 9899));
      centuries[3] = CENTURY_RESET;

      // Directed words, run under the century held after reset.
      add_row(date_word(1900, 1, 1, 0, 0, 0), 1, serial_result(1, 0));
      add_row(date_word(9999, 12, 31, 23, 59, 59), 1, serial_result(SERIAL_MAX, 86399));
      add_row(date_word(0, 3, 1, 12, 0, 0), 0, rejected_result());
      add_row(date_word(99, 12, 31, 1, 2, 3), 0, rejected_result());
      add_row(date_word(100, 6, 15, 0, 0, 0), 1, rejected_result());
      add_row(date_word(1899, 12, 31, 0, 0, 0), 1, rejected_result());
      add_row(date_word(16383, 1, 1, 0, 0, 0), 1, rejected_result());
      add_row(date_word(2024, 0, 1, 0, 0, 0), 1, rejected_result());
      add_row(date_word(2024, 13, 1, 0, 0, 0), 1, rejected_result());
      add_row(date_word(2024, 5, 0, 0, 0, 0), 1, rejected_result());
      add_row(date_word(2023, 4, 31, 0, 0, 0), 1, rejected_result());
      add_row(date_word(1900, 2, 29, 6, 30, 0), 0, rejected_result());
      add_row(date_word(1904, 2, 30, 0, 0, 0), 1, rejected_result());
      add_row(date_word(2100, 7, 4, 24, 0, 0), 1, rejected_result());
      add_row(date_word(2100, 7, 4, 0, 60, 0), 1, rejected_result());
      add_row(date_word(2100, 7, 4, 0, 0, 63), 1, rejected_result());
      add_row(serial_word(0, 0), 1, rejected_result());
      add_row(serial_word(1, 0), 1, date_result(1900, 1, 1, 0, 0, 0, 0));
      add_row(serial_word(SERIAL_MAX, 86399), 1, date_result(9999, 12, 31, 23, 59, 59, 2));
      add_row(serial_word(SERIAL_MAX + 1, 0), 1, rejected_result());
      add_row(serial_word(22'h3FFFFF, 17'h1FFFF), 1, rejected_result());
      add_row(serial_word(40000, SECS_PER_DAY), 1, rejected_result());
      add_row(serial_word(60, 45296), 0, rejected_result());
      add_row(serial_word(367, 86399), 0, rejected_result());
      add_row(serial_word(1461, 3599), 0, rejected_result());

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      n = directed_words.size();
      for (int i = 0; i < n; i++) begin
         want = directed_known[i] ? directed_results[i]
                                  : convert_word(directed_words[i], century_reg);
         send_word(directed_words[i], want);
         if (i + 1 < n && $urandom_range(0, 3) == 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clock);
         end
      end
      req_valid <= 1'b0;
      drain_results();

      // Each century setting gets its own phase, with a full drain halfway through.
      foreach (centuries[k]) begin
         write_century(centuries[k]);
         send_stream(PHASE_WORDS / 2);
         drain_results();
         send_stream(PHASE_WORDS / 2);
         drain_results();
      end

      $display("Checked %0d date to serial and %0d serial to date words, %0d out of range,",
               serial_words, date_words, rejected_words);
      $display("under the reset century and %0d written settings; %0d mismatches.",
               century_writes, mismatch_count);
      if (mismatch_count == 0) begin
         $display("tb_calendar_serial_day_converter_unit passed");
      end else begin
         $display("tb_calendar_serial_day_converter_unit failed");
      end
      $finish;
   end

endmodule
